// ===== rtl/hrp_pkg.sv =====
package hrp_pkg;

    // Field and datapath widths
    localparam int IW            = 32;   // world coordinate width
    localparam int YW            = 16;   // heading width
    localparam int SW            = 16;   // scale register width
    localparam int CW            = 12;   // pixel register width
    localparam int OW            = 16;   // screen coordinate width
    localparam int CORDIC_STAGES = 16;
    localparam int PW            = 43;   // rotation vector width (6 guard bits + growth)
    localparam int ZW            = 34;   // residual angle width
    localparam int QW            = 42;   // magnitude / quotient width
    localparam int KW            = 21;   // gain-and-0.01 constant width
    localparam int HW            = QW - KW;
    localparam int NW            = 64;   // scaled product width
    localparam int QDEPTH        = 4;
    localparam int QAW           = 2;
    localparam int RIW           = 3;    // register index width

    // 0.01 divided by CORDIC gain, Q0.28 scaling
    localparam logic [KW-1:0] SCALE_K = 21'd1630082;

    typedef enum logic [RIW-1:0] {
        REG_SCALE    = 3'd0,
        REG_CENTER_X = 3'd1,
        REG_CENTER_Y = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_TEAM     = 3'd4
    } hrp_reg_t;

    typedef struct packed {
        logic [SW-1:0] scale;
        logic [CW-1:0] center_x;
        logic [CW-1:0] center_y;
        logic [CW-1:0] radius;
        logic          team_check;
    } hrp_cfg_t;

    typedef struct packed {
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        logic signed [ZW-1:0] z;
        logic                 friendly;
    } hrp_item_t;

    // Arctangent of 2^-i in 2^32-per-turn units
    function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        begin
            case (idx)
                5'd0:  r = 34'sd536870912;
                5'd1:  r = 34'sd316933406;
                5'd2:  r = 34'sd167458907;
                5'd3:  r = 34'sd85004756;
                5'd4:  r = 34'sd42667331;
                5'd5:  r = 34'sd21354465;
                5'd6:  r = 34'sd10679838;
                5'd7:  r = 34'sd5340245;
                5'd8:  r = 34'sd2670163;
                5'd9:  r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                5'd24: r = 34'sd41;
                5'd25: r = 34'sd20;
                5'd26: r = 34'sd10;
                5'd27: r = 34'sd5;
                5'd28: r = 34'sd3;
                5'd29: r = 34'sd1;
                5'd30: r = 34'sd1;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/hrp_if.sv =====
interface hrp_req_if import hrp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [IW-1:0] self_x;
    logic signed [IW-1:0] self_z;
    logic signed [IW-1:0] target_x;
    logic signed [IW-1:0] target_z;
    logic        [YW-1:0] yaw;
    logic                 same_team;

    modport source (output valid, self_x, self_z, target_x, target_z, yaw, same_team,
                    input ready);
    modport sink   (input valid, self_x, self_z, target_x, target_z, yaw, same_team,
                    output ready);
endinterface

interface hrp_rsp_if import hrp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [OW-1:0] dot_x;
    logic signed [OW-1:0] dot_y;
    logic                 visible;
    logic                 friendly;

    modport source (output valid, dot_x, dot_y, visible, friendly, input ready);
    modport sink   (input valid, dot_x, dot_y, visible, friendly, output ready);
endinterface

// ===== rtl/hrp_front.sv =====
module hrp_front import hrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hrp_req_if.sink   req,
    input  logic      team_check,
    output hrp_item_t item,
    output logic      item_valid,
    input  logic      item_ready
);

    logic                 f_v_reg;
    hrp_item_t            f_item_reg;
    hrp_item_t            item_next;
    logic signed [IW:0]   dx;
    logic signed [IW:0]   dz;
    logic signed [PW-1:0] p0;
    logic signed [PW-1:0] q0;
    logic        [IW-1:0] ang;
    logic                 fold;

    // Relative vector with guard bits, half-turn fold into [-90, 90)
    always_comb
    begin
        dx   = {req.target_x[IW-1], req.target_x} - {req.self_x[IW-1], req.self_x};
        dz   = {req.target_z[IW-1], req.target_z} - {req.self_z[IW-1], req.self_z};
        p0   = {{(PW-IW-7){dx[IW]}}, dx, 6'b0};
        q0   = {{(PW-IW-7){dz[IW]}}, dz, 6'b0};
        ang  = {req.yaw, 16'b0};
        fold = (req.yaw[YW-1:YW-2] == 2'b01) || (req.yaw[YW-1:YW-2] == 2'b10);
        if (fold)
        begin
            item_next.p = -p0;
            item_next.q = -q0;
            ang         = {~ang[IW-1], ang[IW-2:0]};
        end
        else
        begin
            item_next.p = p0;
            item_next.q = q0;
        end
        item_next.z        = {{(ZW-IW){ang[IW-1]}}, ang};
        item_next.friendly = req.same_team & team_check;
    end

    assign req.ready  = !f_v_reg || item_ready;
    assign item_valid = f_v_reg;
    assign item       = f_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v_reg <= 1'b0;
        else if (req.valid && req.ready)
            f_v_reg <= 1'b1;
        else if (item_ready)
            f_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            f_item_reg <= item_next;
    end

endmodule

// ===== rtl/hrp_queue.sv =====
module hrp_queue import hrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  hrp_item_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output hrp_item_t pop_data
);

    hrp_item_t        mem [QDEPTH];
    logic [QAW-1:0]   wr_reg;
    logic [QAW-1:0]   rd_reg;
    logic [QAW:0]     cnt_reg;
    logic             push;
    logic             pop;

    assign push_ready = (cnt_reg != QAW'(0) + (QAW+1)'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

endmodule

// ===== rtl/hrp_back.sv =====
module hrp_back import hrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hrp_cfg_t  cfg,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  hrp_item_t pop_data,
    hrp_rsp_if.source rsp
);

    logic en;
    logic [SW-1:0] sdiv;
    logic [OW-1:0] lim;

    assign sdiv = (cfg.scale == '0) ? SW'(1) : cfg.scale;
    assign lim  = {cfg.radius, 4'b0};

    // Whole back pipeline moves when the output register can take a beat
    logic o_v_reg;
    assign en        = !o_v_reg || rsp.ready;
    assign pop_ready = en;

    // ---------------- CORDIC rotation stages ----------------
    logic signed [PW-1:0] c_p  [CORDIC_STAGES+1];
    logic signed [PW-1:0] c_q  [CORDIC_STAGES+1];
    logic signed [ZW-1:0] c_z  [CORDIC_STAGES+1];
    logic                 c_fr [CORDIC_STAGES+1];
    logic                 c_v  [CORDIC_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v[0] <= 1'b0;
        else if (en)
            c_v[0] <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_p[0]  <= pop_data.p;
            c_q[0]  <= pop_data.q;
            c_z[0]  <= pop_data.z;
            c_fr[0] <= pop_data.friendly;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        logic signed [PW-1:0] ps;
        logic signed [PW-1:0] qs;
        logic signed [ZW-1:0] at;

        assign ps = c_p[i] >>> i;
        assign qs = c_q[i] >>> i;
        assign at = atan_val(5'(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c_v[i+1] <= 1'b0;
            else if (en)
                c_v[i+1] <= c_v[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_fr[i+1] <= c_fr[i];
                if (!c_z[i][ZW-1])
                begin
                    c_p[i+1] <= c_p[i] - qs;
                    c_q[i+1] <= c_q[i] + ps;
                    c_z[i+1] <= c_z[i] - at;
                end
                else
                begin
                    c_p[i+1] <= c_p[i] + qs;
                    c_q[i+1] <= c_q[i] - ps;
                    c_z[i+1] <= c_z[i] + at;
                end
            end
        end
    end

    // ---------------- Gain and 0.01 multiply, split in halves ----------------
    logic [PW-1:0] abs_x;
    logic [PW-1:0] abs_y;
    logic [QW-1:0] m_hx_reg, m_lx_reg, m_hy_reg, m_ly_reg;
    logic          m_nx_reg, m_ny_reg, m_fr_reg, m_v_reg;

    assign abs_x = c_p[CORDIC_STAGES][PW-1] ? PW'(-c_p[CORDIC_STAGES])
                                            : PW'(c_p[CORDIC_STAGES]);
    assign abs_y = c_q[CORDIC_STAGES][PW-1] ? PW'(-c_q[CORDIC_STAGES])
                                            : PW'(c_q[CORDIC_STAGES]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else if (en)
            m_v_reg <= c_v[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_hx_reg <= QW'(abs_x[QW-1:KW]) * QW'(SCALE_K);
            m_lx_reg <= QW'(abs_x[KW-1:0])  * QW'(SCALE_K);
            m_hy_reg <= QW'(abs_y[QW-1:KW]) * QW'(SCALE_K);
            m_ly_reg <= QW'(abs_y[KW-1:0])  * QW'(SCALE_K);
            m_nx_reg <= c_p[CORDIC_STAGES][PW-1];
            m_ny_reg <= c_q[CORDIC_STAGES][PW-1];
            m_fr_reg <= c_fr[CORDIC_STAGES];
        end
    end

    // ---------------- Rounded dividend: (N + s*2^21) >> 22 ----------------
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [NW-1:0] rnd;

    assign rnd = NW'(sdiv) << (KW);
    assign nx  = (NW'(m_hx_reg) << KW) + NW'(m_lx_reg) + rnd;
    assign ny  = (NW'(m_hy_reg) << KW) + NW'(m_ly_reg) + rnd;

    // ---------------- Restoring divider, one quotient bit per stage ----------------
    logic [QW-1:0] d_a  [2][QW+1];
    logic [SW-1:0] d_r  [2][QW+1];
    logic          d_n  [2][QW+1];
    logic          d_fr [QW+1];
    logic          d_v  [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v[0] <= 1'b0;
        else if (en)
            d_v[0] <= m_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_a[0][0] <= nx[NW-1:KW+1];
            d_a[1][0] <= ny[NW-1:KW+1];
            d_r[0][0] <= '0;
            d_r[1][0] <= '0;
            d_n[0][0] <= m_nx_reg;
            d_n[1][0] <= m_ny_reg;
            d_fr[0]   <= m_fr_reg;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_v[j+1] <= 1'b0;
            else if (en)
                d_v[j+1] <= d_v[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                d_fr[j+1] <= d_fr[j];
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [SW:0] t;
            logic        ge;
            logic [SW:0] diff;

            assign t    = {d_r[l][j], d_a[l][j][QW-1]};
            assign ge   = (t >= {1'b0, sdiv});
            assign diff = t - {1'b0, sdiv};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_r[l][j+1] <= ge ? diff[SW-1:0] : t[SW-1:0];
                    d_a[l][j+1] <= {d_a[l][j][QW-2:0], ge};
                    d_n[l][j+1] <= d_n[l][j];
                end
            end
        end
    end

    // ---------------- Place on screen, saturate, range check ----------------
    logic signed [PW-1:0]  ox;
    logic signed [PW-1:0]  oy;
    logic signed [PW+1:0]  sx;
    logic signed [PW+1:0]  sy;
    logic signed [OW-1:0]  satx;
    logic signed [OW-1:0]  saty;
    logic                  inr;

    always_comb
    begin
        ox = d_n[0][QW] ? -PW'(d_a[0][QW]) : PW'(d_a[0][QW]);
        oy = d_n[1][QW] ? -PW'(d_a[1][QW]) : PW'(d_a[1][QW]);
        sx = $signed({{(PW-CW-2){1'b0}}, cfg.center_x, 4'b0}) + (PW+2)'(ox);
        sy = $signed({{(PW-CW-2){1'b0}}, cfg.center_y, 4'b0}) - (PW+2)'(oy);
        if (sx > (PW+2)'(32767))
            satx = 16'sh7FFF;
        else if (sx < -(PW+2)'(32768))
            satx = 16'sh8000;
        else
            satx = sx[OW-1:0];
        if (sy > (PW+2)'(32767))
            saty = 16'sh7FFF;
        else if (sy < -(PW+2)'(32768))
            saty = 16'sh8000;
        else
            saty = sy[OW-1:0];
        inr = (d_a[0][QW] < QW'(lim)) && (d_a[1][QW] < QW'(lim));
    end

    logic signed [OW-1:0] p1_x_reg, p1_y_reg;
    logic [OW-1:0]        p1_mx_reg, p1_my_reg;
    logic                 p1_in_reg, p1_fr_reg, p1_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_v_reg <= 1'b0;
        else if (en)
            p1_v_reg <= d_v[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_x_reg  <= satx;
            p1_y_reg  <= saty;
            p1_mx_reg <= d_a[0][QW][OW-1:0];
            p1_my_reg <= d_a[1][QW][OW-1:0];
            p1_in_reg <= inr;
            p1_fr_reg <= d_fr[QW];
        end
    end

    // Squares of the offsets and of the radius
    logic signed [OW-1:0] p2_x_reg, p2_y_reg;
    logic [2*OW-1:0]      p2_sx_reg, p2_sy_reg, p2_lim_reg;
    logic                 p2_in_reg, p2_fr_reg, p2_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_v_reg <= 1'b0;
        else if (en)
            p2_v_reg <= p1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_x_reg   <= p1_x_reg;
            p2_y_reg   <= p1_y_reg;
            p2_sx_reg  <= (2*OW)'(p1_mx_reg) * (2*OW)'(p1_mx_reg);
            p2_sy_reg  <= (2*OW)'(p1_my_reg) * (2*OW)'(p1_my_reg);
            p2_lim_reg <= (2*OW)'(lim) * (2*OW)'(lim);
            p2_in_reg  <= p1_in_reg;
            p2_fr_reg  <= p1_fr_reg;
        end
    end

    // Output register
    logic [2*OW:0]        dist2;
    logic signed [OW-1:0] o_x_reg, o_y_reg;
    logic                 o_vis_reg, o_fr_reg;

    assign dist2 = (2*OW+1)'(p2_sx_reg) + (2*OW+1)'(p2_sy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (en)
            o_v_reg <= p2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_x_reg   <= p2_x_reg;
            o_y_reg   <= p2_y_reg;
            o_vis_reg <= p2_in_reg && (dist2 < (2*OW+1)'(p2_lim_reg));
            o_fr_reg  <= p2_fr_reg;
        end
    end

    assign rsp.valid    = o_v_reg;
    assign rsp.dot_x    = o_x_reg;
    assign rsp.dot_y    = o_y_reg;
    assign rsp.visible  = o_vis_reg;
    assign rsp.friendly = o_fr_reg;

endmodule

// ===== rtl/heading_radar_projection_top.sv =====
// Registers from an accepted input beat to its result: front register, queue
// write, 17 CORDIC, 1 multiply, 43 divider, 2 placement stages, and the
// output register.
// Throughput: one beat per cycle; every stage is fully pipelined, and the back
// pipeline only stalls as a whole while a result is held at the output.
// Reset: asynchronous, active low; clears all valid flags and loads the
// register defaults (scale 1.0, center 250/225, radius 100, team check off).
module heading_radar_projection_top import hrp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    hrp_req_if.sink        req,
    hrp_rsp_if.source      rsp,
    input  logic           cfg_we,
    input  logic [RIW-1:0] cfg_index,
    input  logic [SW-1:0]  cfg_wdata
);

    hrp_cfg_t  cfg_reg;
    hrp_item_t f_item;
    logic      f_valid;
    logic      f_ready;
    hrp_item_t q_item;
    logic      q_valid;
    logic      q_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale      <= SW'(256);
            cfg_reg.center_x   <= CW'(250);
            cfg_reg.center_y   <= CW'(225);
            cfg_reg.radius     <= CW'(100);
            cfg_reg.team_check <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (hrp_reg_t'(cfg_index))
                REG_SCALE:    cfg_reg.scale      <= cfg_wdata;
                REG_CENTER_X: cfg_reg.center_x   <= cfg_wdata[CW-1:0];
                REG_CENTER_Y: cfg_reg.center_y   <= cfg_wdata[CW-1:0];
                REG_RADIUS:   cfg_reg.radius     <= cfg_wdata[CW-1:0];
                REG_TEAM:     cfg_reg.team_check <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    hrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .team_check (cfg_reg.team_check),
        .item       (f_item),
        .item_valid (f_valid),
        .item_ready (f_ready)
    );

    hrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_item)
    );

    hrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_item),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/hrp_checker.sv =====
module hrp_checker
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready
);

    logic [7:0] pend_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = req_valid && req_ready;
    assign out_beat = rsp_valid && rsp_ready;

    // Beats inside the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (in_beat && !out_beat)
            pend_reg <= pend_reg + 1'b1;
        else if (out_beat && !in_beat)
            pend_reg <= pend_reg - 1'b1;
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> pend_reg != 8'd0)
        else $error("result without a pending input");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg < 8'd100)
        else $error("more beats in flight than the pipeline holds");

endmodule

bind heading_radar_projection_top hrp_checker u_hrp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
);

// ===== bench/heading_radar_projection_top_tb.sv =====
module heading_radar_projection_top_tb;
    import hrp_pkg::*;

    typedef struct {
        logic signed [IW-1:0] self_x;
        logic signed [IW-1:0] self_z;
        logic signed [IW-1:0] target_x;
        logic signed [IW-1:0] target_z;
        logic        [YW-1:0] yaw;
        logic                 same_team;
    } target_t;

    typedef struct {
        logic signed [OW-1:0] dot_x;
        logic signed [OW-1:0] dot_y;
        logic                 visible;
        logic                 friendly;
    } dot_t;

    // arctan(2^-i) in 2^32-per-turn units
    localparam longint ATAN_TURN[32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 80;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    logic [RIW-1:0] cfg_index;
    logic [SW-1:0]  cfg_wdata;

    hrp_req_if req_bus();
    hrp_rsp_if rsp_bus();

    heading_radar_projection_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus.sink),
        .rsp       (rsp_bus.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // register mirror
    logic [SW-1:0] zoom;
    logic [CW-1:0] ctr_x;
    logic [CW-1:0] ctr_y;
    logic [CW-1:0] rad;
    logic          team_on;

    target_t pending_targets[$];
    dot_t    expected_dots[$];
    target_t on_bus;
    int      errors;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_reqs;
    int      hold_seen;
    int      hold_left;
    int      quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // offset in Q.4 pixels, halves away from zero
    function automatic longint to_pixels(longint v, longint den);
        longint unsigned m;
        longint unsigned r;
        begin
            m = (v < 0) ? -v : v;
            r = (m * longint'(SCALE_K) + den / 2) / den;
            return (v < 0) ? -longint'(r) : longint'(r);
        end
    endfunction

    function automatic logic [OW-1:0] clip16(longint v);
        begin
            if (v > 32767)
                return 16'h7fff;
            if (v < -32768)
                return 16'h8000;
            return v[OW-1:0];
        end
    endfunction

    function automatic dot_t project_target(target_t t);
        longint      p;
        longint      q;
        longint      z;
        longint      ps;
        longint      qs;
        longint      den;
        longint      ox;
        longint      oy;
        longint      lim;
        logic [31:0] ang;
        dot_t        d;
        begin
            p   = (longint'(t.target_x) - longint'(t.self_x)) * 64;
            q   = (longint'(t.target_z) - longint'(t.self_z)) * 64;
            ang = {t.yaw, 16'h0000};
            // second and third quadrant: exact half turn first
            if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2)
            begin
                p   = -p;
                q   = -q;
                ang = ang - 32'h8000_0000;
            end
            z = longint'($signed(ang));
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                ps = p >>> i;
                qs = q >>> i;
                if (z >= 0)
                begin
                    p = p - qs;
                    q = q + ps;
                    z = z - ATAN_TURN[i];
                end
                else
                begin
                    p = p + qs;
                    q = q - ps;
                    z = z + ATAN_TURN[i];
                end
            end
            den = longint'((zoom == 0) ? 1 : zoom) << 22;
            ox  = to_pixels(p, den);
            oy  = to_pixels(q, den);
            lim = longint'(rad) * 16;
            d.visible = 1'b0;
            if (ox < lim && ox > -lim && oy < lim && oy > -lim)
                d.visible = (ox * ox + oy * oy) < lim * lim;
            d.dot_x    = clip16(longint'(ctr_x) * 16 + ox);
            d.dot_y    = clip16(longint'(ctr_y) * 16 - oy);
            d.friendly = t.same_team & team_on;
            return d;
        end
    endfunction

    // sender: predict on each accepted beat, then pick the next one
    initial
    begin
        req_bus.valid = 1'b0;
        req_bus.self_x = '0;
        req_bus.self_z = '0;
        req_bus.target_x = '0;
        req_bus.target_z = '0;
        req_bus.yaw = '0;
        req_bus.same_team = 1'b0;
        rsp_bus.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                expected_dots.push_back(project_target(on_bus));
            if (!req_bus.valid || req_bus.ready)
            begin
                if (pending_targets.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    on_bus = pending_targets.pop_front();
                    req_bus.valid     <= 1'b1;
                    req_bus.self_x    <= on_bus.self_x;
                    req_bus.self_z    <= on_bus.self_z;
                    req_bus.target_x  <= on_bus.target_x;
                    req_bus.target_z  <= on_bus.target_z;
                    req_bus.yaw       <= on_bus.yaw;
                    req_bus.same_team <= on_bus.same_team;
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus an occasional long hold
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            hold_seen     <= 0;
            hold_left     <= 0;
        end
        else if (hold_reqs != hold_seen)
        begin
            hold_seen     <= hold_reqs;
            hold_left     <= LONG_HOLD;
            rsp_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        dot_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_dots.size() == 0)
            begin
                $error("result beat with no expectation pending");
                errors++;
            end
            else
            begin
                want = expected_dots.pop_front();
                if (rsp_bus.dot_x !== want.dot_x)
                begin
                    $error("dot_x expected %0d got %0d", want.dot_x, rsp_bus.dot_x);
                    errors++;
                end
                if (rsp_bus.dot_y !== want.dot_y)
                begin
                    $error("dot_y expected %0d got %0d", want.dot_y, rsp_bus.dot_y);
                    errors++;
                end
                if (rsp_bus.visible !== want.visible)
                begin
                    $error("visible expected %0b got %0b", want.visible, rsp_bus.visible);
                    errors++;
                end
                if (rsp_bus.friendly !== want.friendly)
                begin
                    $error("friendly expected %0b got %0b", want.friendly,
                           rsp_bus.friendly);
                    errors++;
                end
            end
        end
    end

    // watchdog: no beat moving while work is outstanding
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
            || (pending_targets.size() == 0 && !req_bus.valid
                && expected_dots.size() == 0))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // each write drops the enable before the next one starts, so the enable never gets two updates at one edge
    task automatic write_reg(hrp_reg_t idx, logic [SW-1:0] val);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= val;
            @(posedge clk);
            cfg_we    <= 1'b0;
            case (idx)
                REG_SCALE:    zoom    = val;
                REG_CENTER_X: ctr_x   = val[CW-1:0];
                REG_CENTER_Y: ctr_y   = val[CW-1:0];
                REG_RADIUS:   rad     = val[CW-1:0];
                REG_TEAM:     team_on = val[0];
                default: ;
            endcase
        end
    endtask

    task automatic set_regs(logic [SW-1:0] s, logic [CW-1:0] cx, logic [CW-1:0] cy,
                            logic [CW-1:0] r, logic tc);
        begin
            write_reg(REG_SCALE, s);
            write_reg(REG_CENTER_X, {4'h0, cx});
            write_reg(REG_CENTER_Y, {4'h0, cy});
            write_reg(REG_RADIUS, {4'h0, r});
            write_reg(REG_TEAM, {15'h0, tc});
        end
    endtask

    // wait for every queued beat and every result, then let the pipe settle
    task automatic drain();
        begin
            while (pending_targets.size() > 0 || req_bus.valid || expected_dots.size() > 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    function automatic logic signed [IW-1:0] corner_value();
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0;
                default: return -32'sd1;
            endcase
        end
    endfunction

    // mostly targets near the observer so the dot lands on the radar
    function automatic target_t random_target();
        target_t t;
        int      pick;
        int      span;
        begin
            pick = $urandom_range(0, 99);
            span = 10000 * ((zoom == 0) ? 1 : int'(zoom)) / 256 + 16;
            if (pick < 65)
            begin
                t.self_x   = $signed($urandom) >>> 1;
                t.self_z   = $signed($urandom) >>> 1;
                t.target_x = t.self_x + $urandom_range(0, 2 * span) - span;
                t.target_z = t.self_z + $urandom_range(0, 2 * span) - span;
            end
            else if (pick < 90)
            begin
                t.self_x   = $urandom;
                t.self_z   = $urandom;
                t.target_x = $urandom;
                t.target_z = $urandom;
            end
            else
            begin
                t.self_x   = corner_value();
                t.self_z   = corner_value();
                t.target_x = corner_value();
                t.target_z = corner_value();
            end
            t.yaw       = YW'($urandom_range(0, 65535));
            t.same_team = 1'($urandom_range(0, 1));
            return t;
        end
    endfunction

    task automatic add_target(int sx, int sz, int tx, int tz, int yw, bit st);
        target_t t;
        begin
            t.self_x = sx;
            t.self_z = sz;
            t.target_x = tx;
            t.target_z = tz;
            t.yaw = yw[YW-1:0];
            t.same_team = st;
            pending_targets.push_back(t);
        end
    endtask

    task automatic set_idling(int snd, int rcv);
        begin
            send_idle_pct  = snd;
            recv_stall_pct = rcv;
        end
    endtask

    initial
    begin
        errors = 0;
        hold_reqs = 0;
        quiet_cycles = 0;
        zoom = 16'd256;
        ctr_x = 12'd250;
        ctr_y = 12'd225;
        rad = 12'd100;
        team_on = 1'b0;
        set_idling(0, 0);
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SCALE;
        cfg_wdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, then team check on
        add_target(0, 0, 0, 0, 0, 1);                        // zero-length vector
        add_target(100, 200, 100, 200, 12345, 0);
        add_target(0, 0, 5000, 0, 0, 1);
        add_target(0, 0, 0, 5000, 16384, 1);
        add_target(0, 0, 5000, 5000, 32768, 0);
        add_target(0, 0, -3000, 4000, 49152, 1);
        add_target(0, 0, 7000, -2000, 16383, 1);
        add_target(0, 0, -6000, -6000, 65535, 0);
        add_target(0, 0, 9999, 0, 0, 0);                     // near the edge
        add_target(0, 0, 10000, 0, 0, 0);                    // on the edge
        add_target(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                   8192, 1);                                 // huge offsets
        add_target(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                   40000, 0);
        add_target(32'sh7fff_ffff, 0, 32'sh8000_0000, 0, 0, 1);
        add_target(-1, -1, 0, 0, 32767, 1);
        drain();
        write_reg(REG_TEAM, 16'h1);
        add_target(10, 20, 30, 40, 1000, 1);
        add_target(10, 20, 30, 40, 1000, 0);
        add_target(0, 0, 0, 0, 0, 1);
        drain();

        // zero scale is treated as one step
        set_regs(16'd0, 12'd4095, 12'd4095, 12'd4095, 1'b1);
        add_target(0, 0, 1, 1, 0, 1);
        add_target(0, 0, 0, 0, 777, 0);
        add_target(0, 0, 3, -2, 50000, 1);
        drain();
        set_regs(16'd65535, 12'd0, 12'd0, 12'd0, 1'b0);
        add_target(0, 0, 0, 0, 0, 1);                        // zero radius: hidden
        add_target(0, 0, 1000000, 0, 0, 1);
        drain();

        // random phases, cycling registers and idling patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_regs(16'd256, 12'd250, 12'd225, 12'd100, 1'b0);
                1: set_regs(16'd1, 12'd4095, 12'd0, 12'd4095, 1'b1);
                2: set_regs(16'd65535, 12'd0, 12'd4095, 12'd4095, 1'b1);
                3: set_regs(16'd512, 12'd100, 12'd100, 12'd50, 1'b0);
                4: set_regs(16'd128, 12'd2048, 12'd2048, 12'd300, 1'b1);
                5: set_regs(16'd0, 12'd0, 12'd0, 12'd1, 1'b1);
                6: set_regs(SW'($urandom_range(1, 65535)), CW'($urandom_range(0, 4095)),
                             CW'($urandom_range(0, 4095)), CW'($urandom_range(0, 4095)),
                             1'($urandom_range(0, 1)));
                default: set_regs(16'd256, 12'd250, 12'd225, 12'd100, 1'b1);
            endcase
            case (ph % 4)
                0: set_idling(0, 0);
                1: set_idling(76, 0);
                2: set_idling(0, 76);
                default: set_idling(14, 14);
            endcase
            for (int n = 0; n < 85; n++)
                pending_targets.push_back(random_target());
            if (ph == 0)
            begin
                // long receiver hold while the sender keeps offering
                hold_reqs++;
            end
            if (ph == 3)
            begin
                // sender pauses until everything has come back
                while (pending_targets.size() > 40)
                    @(posedge clk);
                begin
                    target_t held[$];
                    held = pending_targets;
                    pending_targets.delete();
                    drain();
                    pending_targets = held;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
